[design/fdss_pkg.sv]
// Shared types, codes and segment tables for the four-digit seven-segment scanner.
`timescale 1ns / 1ps
`default_nettype none

package fdss_pkg;

	typedef logic [3:0] digit_t;
	typedef logic [6:0] seg_t;
	typedef logic [3:0] sel_t;
	typedef logic [1:0] pos_t;
	typedef logic [13:0] value_t;

	// request function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// register indexes
	localparam logic REG_SCAN_REPEATS = 1'b0;

	localparam logic [15:0] SCAN_REPEATS_RESET = 16'd100;
	localparam logic [15:0] NUM_MAX = 16'd9999;
	localparam logic [15:0] PASS_MAX = 16'hffff;
	localparam pos_t POS_LAST = 2'd3;

	// segment pattern for one decimal digit, bit 0 = segment a
	function automatic seg_t seg_pattern(input digit_t d);
		seg_t p;
		case (d)
			4'd0: p = 7'h3f;
			4'd1: p = 7'h06;
			4'd2: p = 7'h5b;
			4'd3: p = 7'h4f;
			4'd4: p = 7'h66;
			4'd5: p = 7'h6d;
			4'd6: p = 7'h7d;
			4'd7: p = 7'h07;
			4'd8: p = 7'h7f;
			4'd9: p = 7'h6f;
			default: p = 7'h00;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

[design/four_digit_seven_segment_scanner_top.sv]
// Four-digit seven-segment scanner: load, scan and pass counting in one module.
//
// Usage: requests enter on the input channel (in_valid/in_stall). func 0 loads
// number (saturated to 9999), converts it to four blank-suppressed segment
// patterns and restarts the scan; it produces no result. func 1 is one scan
// tick and produces one frame on the output channel (out_valid/out_stall) in
// the order ones, hundreds, tens, thousands (select 1, 2, 4, 8).
// A request is registered at the input, then processed into the result
// register. Throughput: one request per cycle unless a stalled frame holds a
// tick; the binary-to-digit conversion is a set of constant compares and
// subtracts between the input and state registers.
// When the receiver stalls, the frame is held in the result register and the
// input stage holds its request; in_stall rises only while both are full.
// Reset clears the patterns to blank, scan position and pass count to zero
// and scan_repeats to 100. scan_repeats is written over the APB port at
// address 0 and read back there; pass_end marks the fourth frame of a pass
// and finished the last frame of the pass that reaches scan_repeats.
`timescale 1ns / 1ps
`default_nettype none

module four_digit_seven_segment_scanner_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [15:0] number,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       digit_select,
	output logic [6:0]       segments,
	output logic [11:0]      serial_frame,
	output logic             pass_end,
	output logic             finished,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// input stage
	logic          valid_s1;
	logic          func_s1;
	logic [15:0]   number_s1;

	// scan state
	fdss_pkg::seg_t digit_pat_q [4];
	fdss_pkg::pos_t scan_pos_q;
	logic [15:0]    pass_count_q;
	logic [15:0]    scan_repeats_q;

	// result register
	logic          out_valid_q;
	fdss_pkg::sel_t sel_q;
	fdss_pkg::seg_t seg_q;
	logic          pass_end_q;
	logic          finished_q;

	logic          advance;
	logic          do_load;
	logic          do_tick;
	logic          in_accept;
	logic          cfg_write;

	fdss_pkg::value_t n_sat;
	fdss_pkg::digit_t th, hu, te, on;
	logic [9:0]    r1;
	logic [6:0]    r2;
	fdss_pkg::seg_t new_pat [4];
	logic          blank_th, blank_hu, blank_te;

	logic          last;
	logic [15:0]   pass_next;
	fdss_pkg::sel_t sel_next;

	// --- handshake ---
	assign advance   = !valid_s1 || (func_s1 == fdss_pkg::FUNC_LOAD) || !out_valid_q || !out_stall;
	assign in_stall  = !advance;
	assign in_accept = in_valid && advance;
	assign do_load   = valid_s1 && advance && (func_s1 == fdss_pkg::FUNC_LOAD);
	assign do_tick   = valid_s1 && advance && (func_s1 == fdss_pkg::FUNC_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1   <= func;
			number_s1 <= number;
		end
	end

	// --- number to digits: parallel constant compares, then subtract ---
	always_comb begin
		n_sat = (number_s1 > fdss_pkg::NUM_MAX) ? fdss_pkg::NUM_MAX[13:0] : number_s1[13:0];
		th = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (n_sat >= 14'(k * 1000)) th = 4'(k);
		end
		r1 = 10'(n_sat - (14'(th) * 14'd1000));
		hu = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (r1 >= 10'(k * 100)) hu = 4'(k);
		end
		r2 = 7'(r1 - (10'(hu) * 10'd100));
		te = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (r2 >= 7'(k * 10)) te = 4'(k);
		end
		on = 4'(r2 - (7'(te) * 7'd10));

		// blank a leading digit while it and everything to its left is zero
		blank_th = (th == 4'd0);
		blank_hu = blank_th && (hu == 4'd0);
		blank_te = blank_hu && (te == 4'd0);

		new_pat[0] = fdss_pkg::seg_pattern(on);
		new_pat[1] = blank_hu ? 7'h00 : fdss_pkg::seg_pattern(hu);
		new_pat[2] = blank_te ? 7'h00 : fdss_pkg::seg_pattern(te);
		new_pat[3] = blank_th ? 7'h00 : fdss_pkg::seg_pattern(th);
	end

	// --- tick: frame and pass counting ---
	always_comb begin
		last      = (scan_pos_q == fdss_pkg::POS_LAST);
		pass_next = pass_count_q;
		if (last && (pass_count_q != fdss_pkg::PASS_MAX)) begin
			pass_next = pass_count_q + 16'd1;
		end
		sel_next = 4'b0001 << scan_pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) digit_pat_q[i] <= 7'h00;
			scan_pos_q   <= 2'd0;
			pass_count_q <= 16'd0;
		end else if (do_load) begin
			for (int i = 0; i < 4; i++) digit_pat_q[i] <= new_pat[i];
			scan_pos_q   <= 2'd0;
			pass_count_q <= 16'd0;
		end else if (do_tick) begin
			scan_pos_q   <= scan_pos_q + 2'd1;
			pass_count_q <= pass_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_tick) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_tick) begin
			sel_q      <= sel_next;
			seg_q      <= digit_pat_q[scan_pos_q];
			pass_end_q <= last;
			finished_q <= last && (scan_repeats_q != 16'd0) && (pass_next == scan_repeats_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign digit_select = sel_q;
	assign segments     = seg_q;
	assign serial_frame = {sel_q, 1'b0, seg_q};
	assign pass_end     = pass_end_q;
	assign finished     = finished_q;

	// --- configuration port ---
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == fdss_pkg::REG_SCAN_REPEATS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_repeats_q <= fdss_pkg::SCAN_REPEATS_RESET;
		end else if (cfg_write) begin
			scan_repeats_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == fdss_pkg::REG_SCAN_REPEATS) ? {16'd0, scan_repeats_q} : 32'd0;

`ifndef SYNTHESIS
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(digit_select))
		else $error("digit_select not one-hot");

	a_pass_end_thousands: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pass_end |-> digit_select == 4'b1000)
		else $error("pass_end off the thousands frame");

	a_finished_on_pass_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> pass_end)
		else $error("finished without pass_end");

	a_stall_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room downstream");

	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		do_load |=> scan_pos_q == 2'd0 && pass_count_q == 16'd0)
		else $error("load did not restart scan");
`endif

endmodule

`default_nettype wire

[tb/fdss_frame_checker.sv]
// Frame checker for the scanner: tracks display state, predicts frames and compares them.
`timescale 1ns / 1ps

module fdss_frame_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        func,
	input  wire logic [15:0] number,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [3:0]  digit_select,
	input  wire logic [6:0]  segments,
	input  wire logic [11:0] serial_frame,
	input  wire logic        pass_end,
	input  wire logic        finished,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic [31:0] prdata,
	input  wire logic        pready,
	output int               failures,
	output int               frames_pending,
	output int               frames_checked,
	output int               loads_seen
);

	typedef struct packed {
		fdss_pkg::sel_t select;
		fdss_pkg::seg_t pattern;
		logic [11:0]    frame;
		logic           pass_end;
		logic           finished;
	} frame_t;

	localparam logic [2:0] REPEATS_ADDR = {fdss_pkg::REG_SCAN_REPEATS, 2'b00};
	// segment patterns indexed by decimal digit, bit 0 = segment a
	localparam logic [9:0][6:0] DIGIT_SEGS = {
		7'h6f, 7'h7f, 7'h07, 7'h7d, 7'h6d, 7'h66, 7'h4f, 7'h5b, 7'h06, 7'h3f
	};

	fdss_pkg::seg_t shown [4];
	fdss_pkg::pos_t scan_pos;
	logic [15:0]    passes;
	logic [15:0]    repeats;
	frame_t         frames_due [$];

	function automatic void load_display(input logic [15:0] raw);
		int n;
		int th;
		int hu;
		int te;
		int on;
		n = (raw > fdss_pkg::NUM_MAX) ? int'(fdss_pkg::NUM_MAX) : int'(raw);
		th = n / 1000;
		hu = (n % 1000) / 100;
		te = (n % 100) / 10;
		on = n % 10;
		shown[0] = DIGIT_SEGS[on];
		shown[1] = (th == 0 && hu == 0) ? '0 : DIGIT_SEGS[hu];
		shown[2] = (th == 0 && hu == 0 && te == 0) ? '0 : DIGIT_SEGS[te];
		shown[3] = (th == 0) ? '0 : DIGIT_SEGS[th];
		scan_pos = '0;
		passes = '0;
	endfunction

	function automatic frame_t scan_tick();
		frame_t f;
		f.select = fdss_pkg::sel_t'(4'b0001 << scan_pos);
		f.pattern = shown[scan_pos];
		f.frame = {f.select, 1'b0, f.pattern};
		f.pass_end = (scan_pos == fdss_pkg::POS_LAST);
		f.finished = 1'b0;
		if (f.pass_end) begin
			// pass count sticks at its maximum
			if (passes != fdss_pkg::PASS_MAX)
				passes = passes + 16'd1;
			f.finished = (repeats != 16'd0) && (passes == repeats);
		end
		scan_pos = scan_pos + 2'd1;
		return f;
	endfunction

	task automatic compare_field(input string name, input logic [11:0] want,
			input logic [11:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_t want;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				shown[i] = '0;
			scan_pos = '0;
			passes = '0;
			repeats = fdss_pkg::SCAN_REPEATS_RESET;
			frames_due.delete();
			failures = 0;
			frames_pending = 0;
			frames_checked = 0;
			loads_seen = 0;
		end else begin
			if (psel && penable && pready && paddr == REPEATS_ADDR) begin
				if (pwrite) begin
					repeats = pwdata[15:0];
				end else if (prdata[15:0] !== repeats) begin
					failures++;
					$display("%0t: scan_repeats read mismatch, expected 0x%0h, got 0x%0h",
						$realtime, repeats, prdata[15:0]);
				end
			end
			if (in_valid && !in_stall) begin
				if (func == fdss_pkg::FUNC_LOAD) begin
					load_display(number);
					loads_seen++;
				end else begin
					frames_due.push_back(scan_tick());
				end
			end
			if (out_valid && !out_stall) begin
				if (frames_due.size() == 0) begin
					failures++;
					$display("%0t: unexpected frame, expected none, got select 0x%0h segments 0x%0h",
						$realtime, digit_select, segments);
				end else begin
					want = frames_due.pop_front();
					compare_field("digit_select", 12'(want.select), 12'(digit_select));
					compare_field("segments", 12'(want.pattern), 12'(segments));
					compare_field("serial_frame", want.frame, serial_frame);
					compare_field("pass_end", 12'(want.pass_end), 12'(pass_end));
					compare_field("finished", 12'(want.finished), 12'(finished));
					frames_checked++;
				end
			end
			frames_pending = frames_due.size();
		end
	end

endmodule

[tb/four_digit_seven_segment_scanner_top_tb.sv]
// Testbench top for the scanner: reset, stimulus, register writes and the verdict.
`timescale 1ns / 1ps

module four_digit_seven_segment_scanner_top_tb;

	localparam int LIMIT_CYCLES = 1_500_000;
	localparam int CHUNK_ITEMS = 54;
	// a short scan under the top repeat count, which is never reached
	localparam int LONG_RUN_TICKS = 12;
	localparam logic [2:0] REPEATS_ADDR = {fdss_pkg::REG_SCAN_REPEATS, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        func = fdss_pkg::FUNC_TICK;
	logic [15:0] number = '0;
	logic        out_stall = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;

	wire logic        in_stall;
	wire logic        out_valid;
	wire logic [3:0]  digit_select;
	wire logic [6:0]  segments;
	wire logic [11:0] serial_frame;
	wire logic        pass_end;
	wire logic        finished;
	wire logic [31:0] prdata;
	wire logic        pready;

	int failures;
	int frames_pending;
	int frames_checked;
	int loads_seen;
	int send_idle_pct = 27;
	int stall_pct = 76;
	int cycles = 0;
	int requests_sent = 0;

	always #1 clk = ~clk;

	four_digit_seven_segment_scanner_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .number(number),
		.out_valid(out_valid), .out_stall(out_stall),
		.digit_select(digit_select), .segments(segments), .serial_frame(serial_frame),
		.pass_end(pass_end), .finished(finished),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	fdss_frame_checker frame_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .number(number),
		.out_valid(out_valid), .out_stall(out_stall),
		.digit_select(digit_select), .segments(segments), .serial_frame(serial_frame),
		.pass_end(pass_end), .finished(finished),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.failures(failures), .frames_pending(frames_pending),
		.frames_checked(frames_checked), .loads_seen(loads_seen)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("[four_digit_seven_segment_scanner_top] ERROR");
			$finish;
		end
	end

	task automatic send_request(input logic f, input logic [15:0] n);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		number <= n;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	task automatic send_ticks(input int count);
		for (int i = 0; i < count; i++)
			send_request(fdss_pkg::FUNC_TICK, 16'($urandom));
	endtask

	// drop valid and wait for every frame in flight
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_access(input logic wr, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= REPEATS_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_repeats(input logic [15:0] value);
		reg_access(1'b1, value);
		reg_access(1'b0, '0);
	endtask

	function automatic logic [15:0] pick_number();
		logic [15:0] n;
		case ($urandom_range(3))
			0: n = 16'($urandom_range(9999));
			1: n = 16'($urandom_range(120));
			2: n = 16'($urandom_range(65535, 10000));
			default: n = 16'($urandom);
		endcase
		return n;
	endfunction

	task automatic random_chunk(input int count);
		int done;
		int burst;
		done = 0;
		while (done < count) begin
			if ($urandom_range(99) < 15) begin
				// stray load or tick
				send_request(logic'($urandom_range(1)), pick_number());
				done++;
			end else begin
				burst = ($urandom_range(1)) ? 4 * $urandom_range(1, 3) : $urandom_range(1, 16);
				send_request(fdss_pkg::FUNC_LOAD, pick_number());
				send_ticks(burst);
				done += burst + 1;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_access(1'b0, '0);
		set_repeats(16'd1);

		// blank frames before any load, then saturation, zeros and blanking
		send_ticks(2);
		send_request(fdss_pkg::FUNC_LOAD, 16'hffff);
		send_ticks(4);
		send_request(fdss_pkg::FUNC_LOAD, 16'd0);
		send_ticks(4);
		send_request(fdss_pkg::FUNC_LOAD, 16'd1002);
		send_ticks(4);
		send_request(fdss_pkg::FUNC_LOAD, 16'd40);
		send_ticks(4);
		send_request(fdss_pkg::FUNC_LOAD, 16'd10000);
		send_ticks(1);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 76 : 0;
			stall_pct = (phase == 0) ? 76 : (phase == 1) ? 27 : 0;
			for (int chunk = 0; chunk < 4; chunk++) begin
				drain();
				// a zero count must never flag finished
				if (phase == 1 && chunk == 0)
					set_repeats(16'd0);
				else
					set_repeats(16'($urandom_range(1, 4)));
				random_chunk(CHUNK_ITEMS);
			end
		end

		drain();
		set_repeats(16'hffff);
		send_request(fdss_pkg::FUNC_LOAD, pick_number());
		send_ticks(LONG_RUN_TICKS);
		drain();
		repeat (8) @(posedge clk);

		$display("Sent %0d requests (%0d loads), checked %0d frames under mixed idling.",
			requests_sent, loads_seen, frames_checked);
		$display("scan_repeats was set to zero, small counts and 65535 between scans.");
		if (failures == 0)
			$display("[four_digit_seven_segment_scanner_top] OK");
		else
			$display("[four_digit_seven_segment_scanner_top] ERROR");
		$finish;
	end

endmodule
